FILE: rtl/pst_pkg.sv
// Package for the process scheduler tick block.
// Holds phase codes, policy codes, register indexes and shared types; no dependencies.
package pst_pkg;

  localparam int unsigned NumProcs = 16;

  // process phase codes
  localparam logic [2:0] PhNotArrived = 3'd0;
  localparam logic [2:0] PhRunning    = 3'd1;
  localparam logic [2:0] PhReady      = 3'd2;
  localparam logic [2:0] PhBlocked    = 3'd3;
  localparam logic [2:0] PhFinished   = 3'd4;

  // policy codes
  localparam logic [1:0] PolFcfs = 2'd0;
  localparam logic [1:0] PolRr   = 2'd1;
  localparam logic [1:0] PolSrtf = 2'd2;

  // register indexes
  localparam logic [1:0] RegPolicy  = 2'd0;
  localparam logic [1:0] RegQuantum = 2'd1;
  localparam logic [1:0] RegCount   = 2'd2;

  // operation codes
  localparam logic OpLoad = 1'b0;
  localparam logic OpTick = 1'b1;

  // one process record as held in the record memory
  typedef struct packed {
    logic [15:0] cpu_left;
    logic [15:0] io_left;
    logic [15:0] half_mark;
    logic [15:0] arrival;
    logic [15:0] finish;
  } rec_t;

endpackage

FILE: rtl/pst_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module pst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/process_scheduler_tick.sv
// Top level of the process scheduler tick block.
// Depends on pst_pkg and pst_ram (record memory).
//
// Usage:
//   Command channel: start_i with operation_i, proc_id_i, cpu_time_i,
//   io_time_i, arrival_i is taken at a rising edge where start_i is high and
//   busy_o is low. A load word writes one process record and makes no result.
//   A tick word advances the schedule one tick and produces one result word
//   per process slot in use, in id order, each shown for one clock cycle with
//   valid_o high; last_o marks the final one.
//   Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   write only while busy_o is low.
// Sequence:
//   A load keeps busy_o high while the record is written, so a new load is
//   taken only after that write. A tick keeps busy_o high through an update
//   pass that reads and then writes each slot's record in the record memory,
//   then a pick and a tally step, then a report pass that reads and outputs
//   each slot in turn. The SRTF minimum search runs during the update pass in
//   a shared compare unit.
// Reset: all phases not arrived, queue empty, counters zero, policy FCFS,
//   quantum 2, one slot in use. Record contents are undefined until loaded.
//   The receiver cannot stall: results are strobed out unconditionally.
module process_scheduler_tick (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        operation_i,
  input  logic [3:0]  proc_id_i,
  input  logic [15:0] cpu_time_i,
  input  logic [15:0] io_time_i,
  input  logic [15:0] arrival_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output logic        valid_o,
  output logic [15:0] cycle_o,
  output logic [3:0]  slot_id_o,
  output logic [2:0]  proc_state_o,
  output logic [15:0] turnaround_o,
  output logic [15:0] busy_cycles_o,
  output logic        all_done_o,
  output logic        last_o
);

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StLoad   = 8'b0000_0010,
    StRead   = 8'b0000_0100,
    StUpd    = 8'b0000_1000,
    StPick   = 8'b0001_0000,
    StDisp   = 8'b0010_0000,
    StOutRd  = 8'b0100_0000,
    StOut    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [1:0] policy_q;
  logic [7:0] quantum_q;
  logic [4:0] pcount_q;

  // scheduler state
  logic [2:0]  phase_q [pst_pkg::NumProcs];
  logic [3:0]  fifo_q  [pst_pkg::NumProcs];
  logic [3:0]  head_q, tail_q;
  logic [4:0]  fcnt_q;
  logic [3:0]  run_slot_q;
  logic        run_valid_q;
  logic [7:0]  slice_q;
  logic [15:0] tick_q, busyc_q;

  // sequencer
  logic [3:0]  idx_q;
  logic [15:0] best_cpu_q;
  logic [3:0]  best_q;
  logic        found_q;
  logic [4:0]  nproc;
  logic [1:0]  pol;
  logic [7:0]  qnt;

  // load word hold
  logic [3:0]  ld_id_q;
  logic [15:0] ld_cpu_q, ld_io_q, ld_arr_q;

  // record memory
  logic        we;
  logic [3:0]  waddr, raddr;
  pst_pkg::rec_t wrec, rrec;

  pst_ram #(.Width($bits(pst_pkg::rec_t)), .Depth(pst_pkg::NumProcs)) u_rec (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wrec),
    .raddr_i (raddr),
    .rdata_o (rrec)
  );

  assign nproc = (pcount_q == 5'd0) ? 5'd1 :
                 (pcount_q > 5'd16) ? 5'd16 : pcount_q;
  assign pol = (policy_q == 2'd3) ? pst_pkg::PolFcfs : policy_q;
  assign qnt = (quantum_q == 8'd0) ? 8'd1 : quantum_q;

  assign busy_o      = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  logic last_idx;
  assign last_idx = ({1'b0, idx_q} + 5'd1 == nproc);

  // per-slot update, shared by all slots of the update pass
  logic [2:0]  cur_ph, nph;
  logic        push, clr_run, bump_busy, clr_slice, inc_slice;
  logic [15:0] cpu_dec, io_dec;
  logic        expired, wants_io;
  pst_pkg::rec_t urec;
  logic [7:0]  slice_inc;

  assign cur_ph    = phase_q[idx_q];
  assign cpu_dec   = rrec.cpu_left - 16'd1;
  assign io_dec    = rrec.io_left - 16'd1;
  assign slice_inc = slice_q + 8'd1;

  always_comb begin
    urec      = rrec;
    nph       = cur_ph;
    push      = 1'b0;
    clr_run   = 1'b0;
    bump_busy = 1'b0;
    clr_slice = 1'b0;
    inc_slice = 1'b0;
    expired   = (pol == pst_pkg::PolRr) && (slice_inc == qnt);
    wants_io  = (cpu_dec <= rrec.half_mark) && (rrec.io_left != 16'd0);
    case (cur_ph)
      pst_pkg::PhNotArrived: begin
        if (rrec.arrival <= tick_q && rrec.cpu_left != 16'd0) begin
          nph  = pst_pkg::PhReady;
          push = (pol != pst_pkg::PolSrtf);
        end
      end
      pst_pkg::PhRunning: begin
        if (rrec.cpu_left != 16'd0) begin
          urec.cpu_left = cpu_dec;
          bump_busy     = 1'b1;
          inc_slice     = (pol == pst_pkg::PolRr);
          if (expired && cpu_dec != 16'd0) begin
            if (wants_io) begin
              nph = pst_pkg::PhBlocked;
            end else begin
              nph  = pst_pkg::PhReady;
              push = 1'b1;
            end
            clr_slice = 1'b1;
            clr_run   = 1'b1;
          end else if (wants_io) begin
            nph       = pst_pkg::PhBlocked;
            clr_run   = 1'b1;
            clr_slice = expired;
          end else if (cpu_dec == 16'd0 && rrec.io_left == 16'd0) begin
            nph         = pst_pkg::PhFinished;
            urec.finish = tick_q - 16'd1;
            clr_run     = 1'b1;
          end
        end
      end
      pst_pkg::PhBlocked: begin
        if (rrec.io_left != 16'd0) begin
          urec.io_left = io_dec;
          if (io_dec == 16'd0) begin
            if (rrec.cpu_left != 16'd0) begin
              nph  = pst_pkg::PhReady;
              push = (pol != pst_pkg::PolSrtf);
            end else begin
              nph         = pst_pkg::PhFinished;
              urec.finish = tick_q - 16'd1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // SRTF candidate after update
  logic        cand;
  logic [15:0] cand_cpu;
  assign cand     = (nph == pst_pkg::PhRunning) || (nph == pst_pkg::PhReady);
  assign cand_cpu = urec.cpu_left;

  logic [3:0] pop_slot;
  assign pop_slot = fifo_q[head_q];

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wrec  = urec;
    raddr = idx_q;
    if (state_q == StLoad) begin
      we             = 1'b1;
      waddr          = ld_id_q;
      wrec.cpu_left  = ld_cpu_q;
      wrec.io_left   = ld_io_q;
      wrec.arrival   = ld_arr_q;
      wrec.half_mark = 16'((17'(ld_cpu_q) + 17'd1) >> 1);
      wrec.finish    = 16'd0;
    end else if (state_q == StUpd) begin
      we = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = (operation_i == pst_pkg::OpLoad) ? StLoad : StRead;
        end
      end
      StLoad:  state_d = StIdle;
      StRead:  state_d = StUpd;
      StUpd:   state_d = last_idx ? StPick : StRead;
      StPick:  state_d = StDisp;
      StDisp:  state_d = StOutRd;
      StOutRd: state_d = StOut;
      StOut:   state_d = last_idx ? StIdle : StOutRd;
      default: state_d = StIdle;
    endcase
  end

  // sequencer and scheduler registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      policy_q    <= pst_pkg::PolFcfs;
      quantum_q   <= 8'd2;
      pcount_q    <= 5'd1;
      for (int i = 0; i < pst_pkg::NumProcs; i++) begin
        phase_q[i] <= pst_pkg::PhNotArrived;
        fifo_q[i]  <= '0;
      end
      head_q      <= '0;
      tail_q      <= '0;
      fcnt_q      <= '0;
      run_slot_q  <= '0;
      run_valid_q <= 1'b0;
      slice_q     <= '0;
      tick_q      <= '0;
      busyc_q     <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      best_q      <= '0;
      best_cpu_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          pst_pkg::RegPolicy:  policy_q  <= cfg_data_i[1:0];
          pst_pkg::RegQuantum: quantum_q <= cfg_data_i;
          pst_pkg::RegCount:   pcount_q  <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      case (state_q)
        StIdle: begin
          idx_q   <= '0;
          found_q <= 1'b0;
        end
        StLoad: begin
          if (run_valid_q && run_slot_q == ld_id_q) begin
            run_valid_q <= 1'b0;
          end
          phase_q[ld_id_q] <= pst_pkg::PhNotArrived;
        end
        StUpd: begin
          phase_q[idx_q] <= nph;
          if (push && fcnt_q != 5'd16) begin
            fifo_q[tail_q] <= idx_q;
            tail_q         <= tail_q + 4'd1;
            fcnt_q         <= fcnt_q + 5'd1;
          end
          if (clr_run)   run_valid_q <= 1'b0;
          if (bump_busy) busyc_q     <= busyc_q + 16'd1;
          if (clr_slice) begin
            slice_q <= '0;
          end else if (inc_slice) begin
            slice_q <= slice_inc;
          end
          // shared compare: strict less keeps the lowest id on ties
          if (cand && (!found_q || cand_cpu < best_cpu_q)) begin
            found_q    <= 1'b1;
            best_q     <= idx_q;
            best_cpu_q <= cand_cpu;
          end
          idx_q <= last_idx ? 4'd0 : idx_q + 4'd1;
        end
        StPick: begin
          if (pol == pst_pkg::PolSrtf) begin
            if (found_q) begin
              // run the winner, demote any other running slot in use
              for (int i = 0; i < pst_pkg::NumProcs; i++) begin
                if (5'(i) < nproc) begin
                  if (4'(i) == best_q) begin
                    phase_q[i] <= pst_pkg::PhRunning;
                  end else if (phase_q[i] == pst_pkg::PhRunning) begin
                    phase_q[i] <= pst_pkg::PhReady;
                  end
                end
              end
              run_slot_q      <= best_q;
              run_valid_q     <= 1'b1;
            end
          end else if (!run_valid_q && fcnt_q != 5'd0) begin
            head_q <= head_q + 4'd1;
            fcnt_q <= fcnt_q - 5'd1;
            if (phase_q[pop_slot] == pst_pkg::PhReady) begin
              phase_q[pop_slot] <= pst_pkg::PhRunning;
              run_slot_q        <= pop_slot;
              run_valid_q       <= 1'b1;
              slice_q           <= '0;
            end
          end
        end
        StOut: begin
          idx_q <= last_idx ? 4'd0 : idx_q + 4'd1;
          if (last_idx) tick_q <= tick_q + 16'd1;
        end
        default: ;
      endcase
    end
  end

  // done tally uses a plain count over the phase bits
  logic [4:0] fin_cnt;
  always_comb begin
    fin_cnt = '0;
    for (int i = 0; i < pst_pkg::NumProcs; i++) begin
      if (5'(i) < nproc && phase_q[i] == pst_pkg::PhFinished) fin_cnt = fin_cnt + 5'd1;
    end
  end

  logic [4:0] done_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_cnt_q <= '0;
    end else if (state_q == StDisp) begin
      done_cnt_q <= fin_cnt;
    end
  end

  // capture load word
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      ld_id_q  <= proc_id_i;
      ld_cpu_q <= cpu_time_i;
      ld_io_q  <= io_time_i;
      ld_arr_q <= arrival_i;
    end
  end

  // result word
  assign valid_o       = (state_q == StOut);
  assign cycle_o       = tick_q;
  assign slot_id_o     = idx_q;
  assign proc_state_o  = phase_q[idx_q];
  assign turnaround_o  = (phase_q[idx_q] == pst_pkg::PhFinished) ?
                         (rrec.finish - rrec.arrival + 16'd1) : 16'd0;
  assign busy_cycles_o = busyc_q;
  assign all_done_o    = (done_cnt_q == nproc);
  assign last_o        = last_idx;

endmodule
